@@ hdl/signed_integer_to_radix_text_top_macros.svh @@
// Assertion macros shared by the radix text blocks.
// Both forms sample on clock and are disabled while reset is high.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SITRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sitrt_pkg.sv @@
// ----------------------------------------------------------------------------
// sitrt_pkg
// Widths, character codes, divider status type and the 64-symbol digit
// alphabet for the radix text converter.
// ----------------------------------------------------------------------------
package sitrt_pkg;

   localparam int RADIX_W = 7;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_AT    = 7'h40;
   localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;

   // Divider handshake status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Map a digit index to its symbol: 0-9, a-z, A-Z, '@', '_'
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      logic [CHAR_W-1:0] ch;
      dx = {1'b0, d};
      if (d < 6'd10) begin
         ch = CHAR_ZERO + dx;
      end else if (d < 6'd36) begin
         ch = CHAR_LOWER + dx - 7'd10;
      end else if (d < 6'd62) begin
         ch = CHAR_UPPER + dx - 7'd36;
      end else if (d == 6'd62) begin
         ch = CHAR_AT;
      end else begin
         ch = CHAR_UNDER;
      end
      return ch;
   endfunction

endpackage

@@ hdl/sitrt_req_if.sv @@
// ----------------------------------------------------------------------------
// sitrt_req_if
// Request channel: one signed integer per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitrt_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/sitrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sitrt_rsp_if
// Response channel: one text character per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitrt_rsp_if;
   import sitrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;
   logic              bad_radix;

   modport source (output valid, output char_code, output last, output bad_radix,
                   input ready);
   modport sink   (input valid, input char_code, input last, input bad_radix,
                   output ready);
endinterface

@@ hdl/sitrt_ram.sv @@
// ----------------------------------------------------------------------------
// sitrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sitrt_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/sitrt_div.sv @@
// ----------------------------------------------------------------------------
// sitrt_div
// Restoring divider: unsigned dividend by a radix of at most 64, one quotient
// bit per cycle, one step per dividend bit, done flagged after the last step.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_top_macros.svh"

module sitrt_div #(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [WIDTH-1:0]               dividend,
   input  logic [sitrt_pkg::RADIX_W-1:0]  divisor,
   output logic [WIDTH-1:0]               quotient,
   output logic [sitrt_pkg::DIGIT_W-1:0]  remainder,
   output sitrt_pkg::div_status_type      status
);
   import sitrt_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]   shr_ff, shr_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RADIX_W:0]   trial;
   logic               fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, shr_ff[WIDTH-1]};
      fits    = trial >= {1'b0, dvs_ff};
      shr_in  = shr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         shr_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         shr_in = {shr_ff[WIDTH-2:0], fits};
         rem_in = fits ? RADIX_W'(trial - {1'b0, dvs_ff}) : trial[RADIX_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      shr_ff <= shr_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = shr_ff;
   assign remainder   = rem_ff[DIGIT_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `SITRT_ASSERT_NOW(a_rem_below_divisor, busy_ff, rem_ff < dvs_ff, "remainder reached divisor")
   `SITRT_ASSERT_NEXT(a_start_busy, start, busy_ff, "divider did not start")
   `SITRT_ASSERT_NOW(a_done_idle, done_ff, !busy_ff, "done while still busy")
endmodule

@@ hdl/signed_integer_to_radix_text_top.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Converts a signed integer to ASCII text in a programmable radix (2..64),
// one character per response, most significant first, '-' for negatives.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------
//  req     | in  | valid/ready | value (VALUE_WIDTH, signed)
//  rsp     | out | valid/ready | char_code (7), last, bad_radix
//  csr     | in  | csr_we      | csr_wdata (7) = radix, reset value 10
//
// A nonzero request runs the shared bit-serial divider once per digit after
// the accept cycle, each remainder going to the digit RAM; then a '-' is sent
// for a negative value, then each digit (RAM read, then emit).
// Zero and bad-radix requests yield one response. Ready is high only when idle.
// A stalled response holds the sequencer; reset is synchronous, active high.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_top_macros.svh"

module signed_integer_to_radix_text_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sitrt_pkg::RADIX_W-1:0] csr_wdata,
   sitrt_req_if.sink                     req,
   sitrt_rsp_if.source                   rsp
);
   import sitrt_pkg::*;

   localparam int ADDR_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ONE  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SIGN = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic               pend_bad_ff, pend_bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [VALUE_WIDTH-1:0] val_u;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   radix_ok;
   logic                   slot_free;
   logic [CNT_W-1:0]       cnt_next;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [DIGIT_W-1:0]     div_rem;
   div_status_type         div_stat;

   logic                   ram_we;
   logic [DIGIT_W-1:0]     ram_rdata;

   // Shared divider
   sitrt_div #(
      .WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_ff),
      .quotient (div_quot),
      .remainder(div_rem),
      .status   (div_stat)
   );

   // Digit store, least significant digit at address 0
   sitrt_ram #(
      .WIDTH(DIGIT_W),
      .DEPTH(VALUE_WIDTH)
   ) u_digits (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cnt_ff[ADDR_W-1:0]),
      .wr_data(div_rem),
      .rd_addr(idx_ff),
      .rd_data(ram_rdata)
   );

   assign val_u     = req.value;
   assign mag       = val_u[VALUE_WIDTH-1] ? (~val_u + 1'b1) : val_u;
   assign radix_ok  = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign cnt_next  = cnt_ff + 1'b1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      radix_in     = csr_we ? csr_wdata : radix_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_char_in = pend_char_ff;
      pend_bad_in  = pend_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      div_start    = 1'b0;
      div_dividend = div_quot;
      ram_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               neg_in = val_u[VALUE_WIDTH-1];
               if (val_u == '0) begin
                  pend_char_in = CHAR_ZERO;
                  pend_bad_in  = 1'b0;
                  state_in     = S_ONE;
               end else if (!radix_ok) begin
                  pend_char_in = CHAR_NUL;
                  pend_bad_in  = 1'b1;
                  state_in     = S_ONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = mag;
                  cnt_in       = '0;
                  state_in     = S_DIV;
               end
            end
         end
         S_ONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = pend_char_ff;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = pend_bad_ff;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            // Store each remainder, divide again while the quotient is nonzero
            if (div_stat.done) begin
               ram_we = 1'b1;
               cnt_in = cnt_next;
               if ((div_quot != '0) && (cnt_next < CNT_W'(VALUE_WIDTH))) begin
                  div_start = 1'b1;
               end else begin
                  idx_in   = cnt_ff[ADDR_W-1:0];
                  state_in = neg_ff ? S_SIGN : S_RD;
               end
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Emit digits from most significant down to address 0
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_char(ram_rdata);
               rsp_last_in  = (idx_ff == '0);
               rsp_bad_in   = 1'b0;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_char_ff <= pend_char_in;
      pend_bad_ff  <= pend_bad_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = rsp_char_ff;
   assign rsp.last      = rsp_last_ff;
   assign rsp.bad_radix = rsp_bad_ff;

   `SITRT_ASSERT_NOW(a_bad_is_nul_last, rsp_valid_ff && rsp_bad_ff, (rsp_char_ff == CHAR_NUL) && rsp_last_ff, "bad radix response malformed")
   `SITRT_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_ff == S_DIV, "divider finished outside divide phase")
   `SITRT_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_ff != S_IDLE, "request accepted but sequencer idle")
   `SITRT_ASSERT_NOW(a_count_bound, 1'b1, cnt_ff <= CNT_W'(VALUE_WIDTH), "digit count overflow")
endmodule
